FILE: sv/ilir_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed list package
// Types, codes and field widths shared by the indexed list insert/remove
// block and its submodules.
// ---------------------------------------------------------------------------
package ilir_pkg;

   localparam int CAPACITY_DEF   = 32;
   localparam int ELEM_WIDTH_DEF = 32;

   localparam int POS_W  = 6;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 6;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SET    = 2'd2,
      OP_GET    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_BAD_POS = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      op_type             opcode;
      logic [POS_W-1:0]   position;
      logic [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [DATA_W-1:0]  read_value;
      logic [LEN_W-1:0]   length;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

FILE: sv/indexed_list_insert_remove.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed list with insert and remove
// Fixed-capacity ordered list of words with insert, remove, set and get
// at a list position.
// ---------------------------------------------------------------------------
// Usage:
// An item on the req_ channel carries an opcode, a position and a value.
// It is taken when req_valid is high and req_stall is low. Each item gives
// exactly one result item on the rsp_ channel with a status, the word read
// by a get, and the list length after the operation.
// An item is captured, then executed once the output register is free;
// rsp_valid is registered from the execute step. The controller keeps the
// input closed until the item executes, so a new item is taken only after
// the last has executed; all later cells of the register row shift at once.
// The result sits in an output register; the next item is accepted while
// it waits, but is not executed until the receiver lowers rsp_stall.
// Reset clears every list cell and sets the length to zero, with no
// separate initialization sequence.
// ---------------------------------------------------------------------------
module indexed_list_insert_remove
   import ilir_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;

   ilir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ilir_dpath #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // An accepted item keeps the input closed for the execute cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted during execute");

   // A result still waiting for the receiver is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !(rsp_valid && rsp_stall))
      else $error("waiting result overwritten");

   // A new result only follows an execute step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.execute))
      else $error("result without execute");

   // Capture and execute never coincide.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.execute))
      else $error("capture and execute in one cycle");

endmodule

FILE: sv/ilir_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed list controller
// Sequences each item through capture and execute, and owns the handshake
// on both channels.
// ---------------------------------------------------------------------------
module ilir_ctrl
   import ilir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign cmd.capture = req_valid && !req_stall;
   // The result register is only loaded once the previous item has left it.
   assign cmd.execute = (state_ff == S_EXEC) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.execute) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/ilir_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed list datapath
// A row of register cells holding the list, the element count, the
// captured request and the result register.
// ---------------------------------------------------------------------------
module ilir_dpath
   import ilir_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   req_type                req_ff;
   rsp_type                rsp_ff, rsp_in;
   logic [ELEM_WIDTH-1:0]  entries_ff [CAPACITY];
   logic [ELEM_WIDTH-1:0]  entries_in [CAPACITY];
   logic [ELEM_WIDTH-1:0]  nbr_lo     [CAPACITY];
   logic [ELEM_WIDTH-1:0]  nbr_hi     [CAPACITY];
   logic [CNT_W-1:0]       count_ff, count_in;

   logic [CMP_W-1:0]       pos_c, n_c;
   logic [ELEM_WIDTH-1:0]  val_e, rd_sel;
   logic                   bad_pos, full, ins_ok, rem_ok, set_ok, get_ok;

   assign pos_c = CMP_W'(req_ff.position);
   assign n_c   = CMP_W'(count_ff);
   assign val_e = ELEM_WIDTH'(req_ff.value);

   // Each cell sees its neighbors at fixed places; the row ends read as zero.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         nbr_lo[i] = '0;
         nbr_hi[i] = '0;
      end
      for (int i = 1; i < CAPACITY; i++) begin
         nbr_lo[i] = entries_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         nbr_hi[i] = entries_ff[i+1];
      end
   end

   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_c == CMP_W'(i)) rd_sel = entries_ff[i];
      end
   end

   always_comb begin
      if (req_ff.opcode == OP_INSERT) begin
         bad_pos = pos_c > n_c;
      end else begin
         bad_pos = pos_c >= n_c;
      end
      full   = (n_c == CMP_W'(CAPACITY));
      ins_ok = (req_ff.opcode == OP_INSERT) && !bad_pos && !full;
      rem_ok = (req_ff.opcode == OP_REMOVE) && !bad_pos;
      set_ok = (req_ff.opcode == OP_SET) && !bad_pos;
      get_ok = (req_ff.opcode == OP_GET) && !bad_pos;
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         count_in = count_ff - CNT_W'(1);
      end

      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (ins_ok) begin
            if (CMP_W'(i) == pos_c) begin
               entries_in[i] = val_e;
            end else if (CMP_W'(i) > pos_c && CMP_W'(i) <= n_c) begin
               entries_in[i] = nbr_lo[i];
            end
         end else if (rem_ok) begin
            // The slot vacated at the old top is cleared.
            if (CMP_W'(i) + CMP_W'(1) == n_c) begin
               entries_in[i] = '0;
            end else if (CMP_W'(i) >= pos_c && CMP_W'(i) + CMP_W'(1) < n_c) begin
               entries_in[i] = nbr_hi[i];
            end
         end else if (set_ok) begin
            if (CMP_W'(i) == pos_c) entries_in[i] = val_e;
         end
      end
   end

   always_comb begin
      if (bad_pos) begin
         rsp_in.status = STAT_BAD_POS;
      end else if (req_ff.opcode == OP_INSERT && full) begin
         rsp_in.status = STAT_FULL;
      end else begin
         rsp_in.status = STAT_OK;
      end
      rsp_in.read_value = get_ok ? DATA_W'(rd_sel) : '0;
      rsp_in.length     = LEN_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            entries_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         count_ff <= count_in;
         for (int i = 0; i < CAPACITY; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.execute) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed list testbench
// Sends insert, remove, set and get items to the list and compares every
// result item with a local prediction of the list contents and length.
// Covers the empty list, edge positions, a full list, and long random runs
// with random gaps on the request side and random stalls on the result side.
// ---------------------------------------------------------------------------
module testbench;
   import ilir_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted list contents and the results still to arrive.
   logic [DATA_W-1:0] list_words [CAPACITY_DEF];
   int                list_len = 0;
   rsp_type           due_results [$];

   int             error_count = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_tick = 0;
   rsp_type        want_rsp;

   indexed_list_insert_remove dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type apply_list_op(input req_type op_item);
      rsp_type res;
      int      n;
      int      p;
      n = list_len;
      p = op_item.position;
      res.status = STAT_OK;
      res.read_value = '0;
      if (op_item.opcode == OP_INSERT) begin
         // A bad position takes precedence over a full list.
         if (p > n) begin
            res.status = STAT_BAD_POS;
         end else if (n >= CAPACITY_DEF) begin
            res.status = STAT_FULL;
         end else begin
            for (int i = n; i > p; i--) list_words[i] = list_words[i - 1];
            list_words[p] = op_item.value;
            list_len = n + 1;
         end
      end else if (p >= n) begin
         res.status = STAT_BAD_POS;
      end else if (op_item.opcode == OP_REMOVE) begin
         for (int i = p; i + 1 < n; i++) list_words[i] = list_words[i + 1];
         list_words[n - 1] = '0;
         list_len = n - 1;
      end else if (op_item.opcode == OP_SET) begin
         list_words[p] = op_item.value;
      end else begin
         res.read_value = list_words[p];
      end
      res.length = LEN_W'(list_len);
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Mostly a position the operation can use, now and then any position.
   function automatic int pick_position(input op_type op);
      int top;
      top = (op == OP_INSERT) ? list_len : list_len - 1;
      if (top < 0 || $urandom_range(0, 6) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, top);
   endfunction

   task automatic send_item(input op_type op, input int pos,
                            input logic [DATA_W-1:0] val);
      req_type item;
      int      gap;
      item.opcode = op;
      item.position = POS_W'(pos);
      item.value = val;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      due_results.push_back(apply_list_op(item));
   endtask

   task automatic test_empty_list();
      send_item(OP_REMOVE, 0, '0);
      send_item(OP_GET, 0, '0);
      send_item(OP_SET, 0, '1);
      send_item(OP_GET, 63, '0);
      send_item(OP_REMOVE, 63, '0);
      send_item(OP_INSERT, 1, 32'h1234_5678);
      send_item(OP_INSERT, 63, '1);
   endtask

   task automatic test_basic_ops();
      send_item(OP_INSERT, 0, '0);
      send_item(OP_INSERT, 1, '1);
      send_item(OP_INSERT, 1, 32'hA5A5_A5A5);
      send_item(OP_INSERT, 3, 32'h5A5A_5A5A);
      send_item(OP_INSERT, 5, 32'hDEAD_BEEF);
      for (int i = 0; i < 4; i++) send_item(OP_GET, i, '0);
      send_item(OP_SET, 3, 32'h1234_5678);
      send_item(OP_GET, 3, '0);
      send_item(OP_REMOVE, 0, '0);
      send_item(OP_REMOVE, 2, '0);
      send_item(OP_GET, 2, '0);
      send_item(OP_REMOVE, 0, '0);
      send_item(OP_REMOVE, 0, '0);
      send_item(OP_GET, 0, '0);
   endtask

   // Fill the list to capacity, poke at the full list, then drain it.
   task automatic test_fill_drain(input int rounds);
      op_type op;
      for (int r = 0; r < rounds; r++) begin
         while (list_len < CAPACITY_DEF) begin
            op = ($urandom_range(0, 4) == 0) ? op_type'($urandom_range(2, 3)) : OP_INSERT;
            send_item(op, pick_position(op), pick_value());
         end
         send_item(OP_INSERT, $urandom_range(0, CAPACITY_DEF), pick_value());
         send_item(OP_INSERT, $urandom_range(CAPACITY_DEF + 1, 63), pick_value());
         send_item(OP_INSERT, CAPACITY_DEF, pick_value());
         send_item(OP_SET, CAPACITY_DEF - 1, pick_value());
         send_item(OP_GET, CAPACITY_DEF - 1, '0);
         send_item(OP_GET, CAPACITY_DEF, '0);
         while (list_len > 0) begin
            op = ($urandom_range(0, 4) == 0) ? OP_GET : OP_REMOVE;
            send_item(op, pick_position(op), pick_value());
         end
         send_item(OP_REMOVE, 0, '0);
         send_item(OP_GET, $urandom_range(0, 63), '0);
      end
   endtask

   task automatic test_random_mix(input int count);
      op_type op;
      for (int k = 0; k < count; k++) begin
         // Steer the length away from the ends so every operation stays live.
         if (list_len < 4 && $urandom_range(0, 1) == 0) op = OP_INSERT;
         else if (list_len > 28 && $urandom_range(0, 1) == 0) op = OP_REMOVE;
         else op = op_type'($urandom_range(0, 3));
         send_item(op, pick_position(op), pick_value());
      end
   endtask

   task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result item: expected none, actual %0h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want_rsp = due_results.pop_front();
            if (rsp_data.status !== want_rsp.status)
               report_field("status", DATA_W'(want_rsp.status),
                            DATA_W'(rsp_data.status));
            if (rsp_data.read_value !== want_rsp.read_value)
               report_field("read_value", want_rsp.read_value, rsp_data.read_value);
            if (rsp_data.length !== want_rsp.length)
               report_field("length", DATA_W'(want_rsp.length),
                            DATA_W'(rsp_data.length));
         end
      end
   end

   // The receiver switches between stall patterns every so often.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(64, 256);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_tick % 5) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles with no item moving", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < CAPACITY_DEF; i++) list_words[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_ops();
      test_fill_drain(5);
      test_random_mix(500);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && due_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/ilir_pkg.sv
sv/ilir_ctrl.sv
sv/ilir_dpath.sv
sv/indexed_list_insert_remove.sv
sim/testbench.sv
